[src/bdpc_pkg.sv]
package bdpc_pkg;

    // Timestamp arithmetic width; differences wrap modulo 2^TIME_WIDTH
    localparam int TIME_WIDTH = 32;
    localparam int NOW_WIDTH  = 32;
    localparam int CFG_WIDTH  = 16;
    localparam int CFG_IDX_W  = 2;

    typedef logic [TIME_WIDTH-1:0] t_time;

    // Event codes of a result word
    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PRESSED  = 3'd1,
        EV_CLICK    = 3'd2,
        EV_LONG     = 3'd3,
        EV_RELEASED = 3'd4
    } t_event;

    // Command codes of an input word
    typedef enum logic {
        CMD_POLL = 1'b0,
        CMD_INIT = 1'b1
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_HIGH = 2'd0,
        CFG_DEBOUNCE    = 2'd1,
        CFG_SHORT_PRESS = 2'd2,
        CFG_LONG_PRESS  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                  cmd;
        logic                  raw_level;
        logic [NOW_WIDTH-1:0]  now_ms;
    } t_in_word;

    typedef struct packed {
        t_event event_kind;
        logic   pressed_flag;
        logic   long_pressed_flag;
    } t_out_word;

    typedef struct packed {
        logic                 active_high;
        logic [CFG_WIDTH-1:0] debounce_time;
        logic [CFG_WIDTH-1:0] short_press_time;
        logic [CFG_WIDTH-1:0] long_press_time;
    } t_cfg;

    typedef struct packed {
        logic  last_raw_pressed;
        logic  stable_pressed;
        t_time last_change_time;
        t_time press_start_time;
        logic  long_fired;
        logic  ignore_until_release;
    } t_state;

    localparam t_cfg CFG_RESET = '{
        active_high:      1'b1,
        debounce_time:    CFG_WIDTH'(50),
        short_press_time: CFG_WIDTH'(50),
        long_press_time:  CFG_WIDTH'(1000)
    };

endpackage

[src/bdpc_in_if.sv]
interface bdpc_in_if;
    logic                 valid;
    logic                 ready;
    bdpc_pkg::t_in_word   word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

[src/bdpc_out_if.sv]
interface bdpc_out_if;
    logic                 valid;
    logic                 ready;
    bdpc_pkg::t_out_word  word;

    modport source (output valid, output word, input ready);
    modport sink   (input valid, input word, output ready);
endinterface

[src/bdpc_step.sv]
module bdpc_step (
    input  bdpc_pkg::t_cfg      i_cfg,
    input  bdpc_pkg::t_state    i_state,
    input  bdpc_pkg::t_in_word  i_word,
    output bdpc_pkg::t_state    o_state,
    output bdpc_pkg::t_out_word o_result
);
    import bdpc_pkg::*;

    logic   raw;
    t_time  now;
    t_time  change_time;
    t_time  db_elapsed;
    t_time  hold_elapsed;
    t_state st;
    t_event ev;

    // Level to pressed through polarity
    assign raw          = i_cfg.active_high ? i_word.raw_level : ~i_word.raw_level;
    assign now          = TIME_WIDTH'(i_word.now_ms);
    assign change_time  = (raw != i_state.last_raw_pressed) ? now : i_state.last_change_time;
    assign db_elapsed   = now - change_time;
    assign hold_elapsed = now - i_state.press_start_time;

    // Next state and event for one word
    always_comb begin
        st = i_state;
        ev = EV_NONE;
        if (i_word.cmd == CMD_INIT) begin
            st.last_raw_pressed     = raw;
            st.stable_pressed       = raw;
            st.last_change_time     = now;
            st.press_start_time     = now;
            st.long_fired           = 1'b0;
            st.ignore_until_release = raw;
        end else begin
            st.last_raw_pressed = raw;
            st.last_change_time = change_time;
            if (db_elapsed < TIME_WIDTH'(i_cfg.debounce_time)) begin
                ev = EV_NONE;
            end else if (raw != i_state.stable_pressed) begin
                // debounced edge
                st.stable_pressed = raw;
                if (i_state.ignore_until_release) begin
                    if (!raw) begin
                        st.ignore_until_release = 1'b0;
                    end
                end else if (raw) begin
                    st.press_start_time = now;
                    st.long_fired       = 1'b0;
                    ev                  = EV_PRESSED;
                end else if (i_state.long_fired) begin
                    ev = EV_RELEASED;
                end else if (hold_elapsed >= TIME_WIDTH'(i_cfg.short_press_time)) begin
                    ev = EV_CLICK;
                end
            end else if (!i_state.ignore_until_release && i_state.stable_pressed &&
                         !i_state.long_fired &&
                         hold_elapsed >= TIME_WIDTH'(i_cfg.long_press_time)) begin
                // held past the long time, fire once
                st.long_fired = 1'b1;
                ev            = EV_LONG;
            end
        end
    end

    assign o_state                    = st;
    assign o_result.event_kind        = ev;
    assign o_result.pressed_flag      = st.stable_pressed & ~st.ignore_until_release;
    assign o_result.long_pressed_flag = st.stable_pressed & st.long_fired &
                                        ~st.ignore_until_release;

endmodule

[src/button_debounce_press_classifier.sv]
// Channel | Dir | Payload                                     | Handshake
// i_in    | in  | cmd, raw_level, now_ms                      | valid/ready
// o_res   | out | event_kind, pressed_flag, long_pressed_flag | valid/ready
// i_cfg_* | in  | register index, 16-bit write data           | write enable
//
// One word per cycle sustained while the result side is ready. An accepted word
// passes through the input register, then the state update and the result
// register, where its result is valid and held until the result side takes it.
// The debounce state and the result register load together, so each word sees
// the state left by the one before it.
// Synchronous active-low reset clears the valid bits and the debounce state and
// loads the register defaults. A stalled result holds both stages; the input
// side stays ready while the input stage is empty.
module button_debounce_press_classifier (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    bdpc_in_if.sink                              i_in,
    bdpc_out_if.source                           o_res,
    input  logic                                 i_cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bdpc_pkg::CFG_WIDTH-1:0]       i_cfg_wdata
);
    import bdpc_pkg::*;

    t_cfg      r_cfg;
    t_state    r_st;
    t_state    n_st;
    logic      r_in_valid;
    t_in_word  r_in_word;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out_word;
    logic      advance;
    logic      in_take;

    // Pipeline handshake
    assign advance     = r_in_valid & (~r_out_valid | o_res.ready);
    assign i_in.ready  = ~r_in_valid | ~r_out_valid | o_res.ready;
    assign in_take     = i_in.valid & i_in.ready;
    assign o_res.valid = r_out_valid;
    assign o_res.word  = r_out_word;

    bdpc_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_st),
        .i_word   (r_in_word),
        .o_state  (n_st),
        .o_result (n_out_word)
    );

    // Control, state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
            r_cfg       <= CFG_RESET;
        end else begin
            r_in_valid  <= in_take | (r_in_valid & ~advance);
            r_out_valid <= advance | (r_out_valid & ~o_res.ready);
            if (advance) begin
                r_st <= n_st;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ACTIVE_HIGH: r_cfg.active_high      <= i_cfg_wdata[0];
                    CFG_DEBOUNCE:    r_cfg.debounce_time    <= i_cfg_wdata;
                    CFG_SHORT_PRESS: r_cfg.short_press_time <= i_cfg_wdata;
                    CFG_LONG_PRESS:  r_cfg.long_press_time  <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word <= i_in.word;
        end
        if (advance) begin
            r_out_word <= n_out_word;
        end
    end

    // The pressed flag in a result agrees with the state it left behind
    a_flag_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> (r_out_word.pressed_flag ==
                     (r_st.stable_pressed & ~r_st.ignore_until_release)))
        else $error("pressed flag out of step with state");

    a_long_implies_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_word.long_pressed_flag && !r_out_word.pressed_flag))
        else $error("long pressed flag without pressed flag");

    a_long_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.event_kind == EV_LONG) |-> r_st.long_fired)
        else $error("long press event without long_fired");

    a_press_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.event_kind == EV_PRESSED) |->
            (r_st.stable_pressed && !r_st.long_fired))
        else $error("press event with wrong state");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_res.ready) |-> !i_in.ready)
        else $error("input accepted with both stages full");

endmodule

[tb/sv/button_debounce_press_classifier_test.sv]
module button_debounce_press_classifier_test;
    import bdpc_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 11;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 1500;
    localparam int SETTLE_CYCLES   = 4;
    localparam int REPORT_MAX      = 10;
    localparam int PHASE_WORDS     = 125;
    localparam int RANDOM_PHASES   = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_WIDTH-1:0] cfg_wdata;

    bdpc_in_if  in_ch ();
    bdpc_out_if res_ch ();

    button_debounce_press_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // Shadow of the configuration and of the button state
    t_cfg      cfg_shadow;
    t_state    btn;
    t_out_word expected_events [$];

    int unsigned fail_count   = 0;
    int unsigned words_sent   = 0;
    int unsigned stall_cycles = 0;
    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          hold_off_req = 1'b0;
    t_time       now_cur;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Predict the result of one accepted input word and advance the shadow state
    function automatic t_out_word predict_press(t_in_word w);
        logic      pr;
        t_time     now;
        t_event    kind;
        t_out_word r;
        pr   = cfg_shadow.active_high ? w.raw_level : ~w.raw_level;
        now  = t_time'(w.now_ms);
        kind = EV_NONE;
        if (w.cmd == CMD_INIT) begin
            btn.last_raw_pressed     = pr;
            btn.stable_pressed       = pr;
            btn.last_change_time     = now;
            btn.press_start_time     = now;
            btn.long_fired           = 1'b0;
            btn.ignore_until_release = pr;
        end else begin
            // any raw change restarts the debounce window
            if (pr != btn.last_raw_pressed) begin
                btn.last_change_time = now;
                btn.last_raw_pressed = pr;
            end
            if (t_time'(now - btn.last_change_time) >= t_time'(cfg_shadow.debounce_time)) begin
                if (pr != btn.stable_pressed) begin
                    btn.stable_pressed = pr;
                    if (btn.ignore_until_release) begin
                        if (!pr) btn.ignore_until_release = 1'b0;
                    end else if (pr) begin
                        btn.press_start_time = now;
                        btn.long_fired       = 1'b0;
                        kind                 = EV_PRESSED;
                    end else if (btn.long_fired) begin
                        kind = EV_RELEASED;
                    end else if (t_time'(now - btn.press_start_time) >=
                                 t_time'(cfg_shadow.short_press_time)) begin
                        kind = EV_CLICK;
                    end
                end else if (!btn.ignore_until_release && btn.stable_pressed &&
                             !btn.long_fired &&
                             t_time'(now - btn.press_start_time) >=
                             t_time'(cfg_shadow.long_press_time)) begin
                    btn.long_fired = 1'b1;
                    kind           = EV_LONG;
                end
            end
        end
        r.event_kind        = kind;
        r.pressed_flag      = btn.stable_pressed & ~btn.ignore_until_release;
        r.long_pressed_flag = btn.stable_pressed & btn.long_fired & ~btn.ignore_until_release;
        return r;
    endfunction

    // Offer one input word, wait for its accept, record its expected result
    task automatic send_word(t_cmd cmd, logic lvl, t_time t);
        int       gap;
        t_in_word w;
        w.cmd       = cmd;
        w.raw_level = lvl;
        w.now_ms    = t;
        gap = src_idle_on ? int'($urandom_range(0, 15)) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.word  <= w;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        expected_events.push_back(predict_press(w));
        words_sent++;
    endtask

    task automatic poll_after(logic lvl, int unsigned dt);
        now_cur = now_cur + t_time'(dt);
        send_word(CMD_POLL, lvl, now_cur);
    endtask

    // Stop offering, wait for every expected result, let the pipeline empty
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_events.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [CFG_WIDTH-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ACTIVE_HIGH: cfg_shadow.active_high      = val[0];
            CFG_DEBOUNCE:    cfg_shadow.debounce_time    = val;
            CFG_SHORT_PRESS: cfg_shadow.short_press_time = val;
            CFG_LONG_PRESS:  cfg_shadow.long_press_time  = val;
            default: ;
        endcase
    endtask

    // Registers change only with the block idle
    task automatic set_config(logic ah, logic [CFG_WIDTH-1:0] db,
                              logic [CFG_WIDTH-1:0] sh, logic [CFG_WIDTH-1:0] lg);
        drain();
        write_cfg(CFG_ACTIVE_HIGH, CFG_WIDTH'(ah));
        write_cfg(CFG_DEBOUNCE, db);
        write_cfg(CFG_SHORT_PRESS, sh);
        write_cfg(CFG_LONG_PRESS, lg);
    endtask

    function automatic logic [CFG_WIDTH-1:0] pick_threshold();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return CFG_WIDTH'($urandom_range(1, 40));
            default: return CFG_WIDTH'($urandom_range(41, 1200));
        endcase
    endfunction

    // One press with contact bounce, a hold of random class, a bouncy release
    task automatic press_episode();
        logic        down;
        int unsigned db, sh, lg, hold, span, step, acc, k;
        down = cfg_shadow.active_high;
        db   = cfg_shadow.debounce_time;
        sh   = cfg_shadow.short_press_time;
        lg   = cfg_shadow.long_press_time;
        case ($urandom_range(0, 2))
            0:       hold = $urandom_range(0, sh);
            1:       hold = $urandom_range(sh, (lg > sh) ? lg : sh);
            default: hold = lg + $urandom_range(0, lg + 20);
        endcase
        // bounce on press, edges mostly inside the window
        k = $urandom_range(0, 4);
        for (int i = 0; i < k; i++) poll_after(i[0] ? ~down : down, $urandom_range(0, db));
        // hold pressed
        span = db + hold + 1;
        acc  = 0;
        for (int i = 0; i < 12 && acc < span; i++) begin
            step = (i == 11) ? span - acc : $urandom_range(1, span / 4 + 1);
            acc += step;
            poll_after(down, step);
        end
        // bounce on release
        k = $urandom_range(0, 4);
        for (int i = 0; i < k; i++) poll_after(i[0] ? down : ~down, $urandom_range(0, db));
        span = db + 1;
        acc  = 0;
        for (int i = 0; i < 6 && acc < span; i++) begin
            step = (i == 5) ? span - acc : $urandom_range(1, span / 2 + 1);
            acc += step;
            poll_after(~down, step);
        end
        repeat ($urandom_range(0, 2)) poll_after(~down, $urandom_range(0, 3));
    endtask

    // Press, long press, released, then a click, with the reset thresholds
    task automatic test_default_timing();
        send_word(CMD_POLL, 1'b0, 32'd0);
        send_word(CMD_POLL, 1'b1, 32'd10);
        send_word(CMD_POLL, 1'b1, 32'd60);
        send_word(CMD_POLL, 1'b1, 32'd1060);
        send_word(CMD_POLL, 1'b0, 32'd1100);
        send_word(CMD_POLL, 1'b0, 32'd1150);
        send_word(CMD_POLL, 1'b1, 32'd1200);
        send_word(CMD_POLL, 1'b1, 32'd1250);
        send_word(CMD_POLL, 1'b0, 32'd1260);
        send_word(CMD_POLL, 1'b0, 32'd1310);
    endtask

    // Init while held: press ignored until release; timestamps wrap
    task automatic test_init_ignore();
        send_word(CMD_INIT, 1'b1, 32'hFFFF_FF00);
        send_word(CMD_POLL, 1'b1, 32'hFFFF_FFFF);
        send_word(CMD_POLL, 1'b1, 32'h0000_0400);
        send_word(CMD_POLL, 1'b0, 32'h0000_0410);
        send_word(CMD_POLL, 1'b0, 32'h0000_0450);
        send_word(CMD_INIT, 1'b0, 32'h0000_0000);
    endtask

    // Active low, immediate accept, long press on first held poll, short release
    task automatic test_zero_thresholds();
        set_config(1'b0, 16'd0, 16'd100, 16'd0);
        send_word(CMD_POLL, 1'b0, 32'd5);
        send_word(CMD_POLL, 1'b0, 32'd6);
        send_word(CMD_POLL, 1'b1, 32'd7);
        send_word(CMD_POLL, 1'b0, 32'd8);
        send_word(CMD_POLL, 1'b1, 32'd9);
    endtask

    task automatic test_max_thresholds();
        set_config(1'b1, '1, '1, '1);
        send_word(CMD_POLL, 1'b1, 32'h8000_0000);
        send_word(CMD_POLL, 1'b1, 32'h8000_FFFF);
        send_word(CMD_POLL, 1'b0, 32'h8001_0000);
        send_word(CMD_POLL, 1'b0, 32'h8001_FFFF);
    endtask

    // Result side holds off while words keep coming, so the input stalls
    task automatic test_input_stall();
        set_config(1'b1, 16'd8, 16'd20, 16'd60);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        now_cur      = $urandom();
        hold_off_req = 1'b1;
        repeat (3) press_episode();
        drain();
    endtask

    task automatic test_random_traffic();
        int unsigned phase_end;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) set_config(1'b1, 16'd50, 16'd50, 16'd1000);
            else set_config(1'($urandom_range(0, 1)), pick_threshold(), pick_threshold(),
                            pick_threshold());
            now_cur   = $urandom();
            phase_end = words_sent + PHASE_WORDS;
            while (words_sent < phase_end) begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 5) == 0) begin
                    // noise: stray inits, random levels, timestamp jumps
                    repeat ($urandom_range(1, 5)) begin
                        if ($urandom_range(0, 3) == 0) now_cur = $urandom();
                        else now_cur = now_cur + t_time'($urandom_range(0, 64));
                        send_word(($urandom_range(0, 4) == 0) ? CMD_INIT : CMD_POLL,
                                  1'($urandom_range(0, 1)), now_cur);
                    end
                end else begin
                    press_episode();
                end
            end
        end
    endtask

    // Result receiver: random stall per word, long hold-off on request
    initial begin : result_sink
        int pause;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_off_req) begin
                pause        = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end else begin
                pause = sink_idle_on ? int'($urandom_range(0, 15)) : 0;
            end
            if (pause > 0) begin
                @(negedge i_clk);
                res_ch.ready <= 1'b0;
                repeat (pause - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (res_ch.valid !== 1'b1);
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out_word want;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (expected_events.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected result word: kind=%0d pressed=%0b long=%0b",
                             res_ch.word.event_kind, res_ch.word.pressed_flag,
                             res_ch.word.long_pressed_flag);
            end else begin
                want = expected_events.pop_front();
                if (res_ch.word.event_kind !== want.event_kind ||
                    res_ch.word.pressed_flag !== want.pressed_flag ||
                    res_ch.word.long_pressed_flag !== want.long_pressed_flag) begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display({"result mismatch: expected kind=%0d pressed=%0b long=%0b,",
                                  " got kind=%0d pressed=%0b long=%0b"},
                                 want.event_kind, want.pressed_flag, want.long_pressed_flag,
                                 res_ch.word.event_kind, res_ch.word.pressed_flag,
                                 res_ch.word.long_pressed_flag);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we ||
            (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Main sequence
    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.word   = '0;
        res_ch.ready = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_wdata    = '0;
        cfg_shadow   = CFG_RESET;
        btn          = '0;
        now_cur      = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_timing();
        test_init_ignore();
        test_zero_thresholds();
        test_max_thresholds();
        test_input_stall();
        test_random_traffic();
        drain();

        if (fail_count == 0 && expected_events.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
